/* hw/rtl/jcj_pkg.sv */
// ----------------------------------------------------------------------------
// jcj_pkg
// shared constants, codes and pipeline types of the joint chain jacobian core
// ----------------------------------------------------------------------------
package jcj_pkg;

   localparam int DEF_MAX_JOINTS = 3;
   localparam int DEF_FRAC_BITS  = 16;
   localparam int DATA_W         = 32;
   // wide enough for every chain address up to eight joints
   localparam int DEST_W         = 7;
   localparam int SEL_W          = 3;

   // request codes
   localparam logic [1:0] REQ_LOAD    = 2'd0;
   localparam logic [1:0] REQ_COMPUTE = 2'd1;
   localparam logic [1:0] REQ_CLEAR   = 2'd2;

   // result status codes
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_EMPTY    = 2'd1;
   localparam logic [1:0] STAT_OVERFLOW = 2'd2;

   // one product entering the multiply-accumulate pipeline
   typedef struct packed {
      logic              valid;
      logic              first;
      logic              last;
      logic              sub;
      logic              is_cross;
      logic [SEL_W-1:0]  sel;
      logic [DEST_W-1:0] dest;
   } mac_tag_type;

   // one finished, saturated sum leaving the pipeline
   typedef struct packed {
      logic                     valid;
      logic                     busy;
      logic                     is_cross;
      logic [DEST_W-1:0]        dest;
      logic signed [DATA_W-1:0] value;
   } mac_res_type;

endpackage

/* hw/rtl/joint_chain_jacobian_core.sv */
// ----------------------------------------------------------------------------
// joint_chain_jacobian_core
// linear part of the geometric jacobian of a revolute joint chain, Q16.16
// ----------------------------------------------------------------------------
// A load transaction writes one transform row; a clear resets the joint count
// and the overflow flag. A compute transaction copies the first joint, multiplies
// the chain through one shared 32x32 multiplier at one product per cycle and
// drains the pipeline, fetches the end origin, works column 0 (six products,
// drain and presenting the result) and then each later column, which first
// fetches z and origin. The core has a single multiplier and a single read
// port on each store. The input side is ready only while the sequencer is
// idle; a result waits in the output register.
// ----------------------------------------------------------------------------
module joint_chain_jacobian_core #(
   parameter int MAX_JOINTS = jcj_pkg::DEF_MAX_JOINTS,
   parameter int FRAC_BITS  = jcj_pkg::DEF_FRAC_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_type,
   input  logic [1:0]         req_row_index,
   input  logic signed [31:0] req_elem_0,
   input  logic signed [31:0] req_elem_1,
   input  logic signed [31:0] req_elem_2,
   input  logic signed [31:0] req_elem_3,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_column,
   output logic signed [31:0] rsp_jac_x,
   output logic signed [31:0] rsp_jac_y,
   output logic signed [31:0] rsp_jac_z,
   output logic               rsp_last,
   output logic [1:0]         rsp_status
);
   import jcj_pkg::*;

   localparam int JW    = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
   localparam int AW    = JW + 4;
   localparam int DEPTH = MAX_JOINTS * 16;
   localparam int RAW   = $clog2(DEPTH);
   localparam int CW    = $clog2(MAX_JOINTS + 1);
   localparam logic signed [31:0] ONE = 32'(1) << FRAC_BITS;

   typedef enum logic [3:0] {
      ST_IDLE, ST_LOAD, ST_COPY, ST_MAT, ST_MAT_DRAIN, ST_FETCH_E,
      ST_FETCH_ZO, ST_CROSS, ST_CROSS_DRAIN, ST_EMIT
   } state_type;

   state_type          state_ff;
   logic [CW-1:0]      count_ff;
   logic               ovf_ff;
   logic               err_ff;
   logic [1:0]         row_ff;
   logic signed [31:0] elem_ff [4];
   logic [4:0]         cnt_ff;
   logic [JW-1:0]      k_ff;
   logic [1:0]         r_ff, c_ff, m_ff;
   logic [JW:0]        i_ff;
   logic signed [31:0] e_ff [3];
   logic signed [31:0] z_ff [3];
   logic signed [31:0] o_ff [3];
   logic signed [31:0] res_ff [3];
   mac_tag_type        tag1_ff, tag_in;

   logic               rsp_valid_ff, rsp_last_ff;
   logic [1:0]         rsp_column_ff, rsp_status_ff;
   logic signed [31:0] rsp_x_ff, rsp_y_ff, rsp_z_ff;

   logic               jwr_en, cwr_en;
   logic [AW-1:0]      jwr_addr, jrd_addr, cwr_addr, crd_addr;
   logic [31:0]        jwr_data, cwr_data, jrd_data, crd_data;
   logic signed [31:0] op_a, op_b;
   mac_res_type        mac_res;
   logic [JW-1:0]      last_joint, prev_joint;
   logic [2:0]         zo_idx;
   logic [1:0]         cap_idx;
   logic               drained, final_col;

   function automatic logic signed [31:0] sat_diff(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
      logic signed [32:0] d;
      d = {a[31], a} - {b[31], b};
      if (d[32] != d[31]) begin
         return d[32] ? 32'sh80000000 : 32'sh7fffffff;
      end
      return signed'(d[31:0]);
   endfunction

   jcj_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_joint_ram (
      .clock(clock), .wr_en(jwr_en), .wr_addr(jwr_addr[RAW-1:0]), .wr_data(jwr_data),
      .rd_addr(jrd_addr[RAW-1:0]), .rd_data(jrd_data)
   );

   jcj_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_chain_ram (
      .clock(clock), .wr_en(cwr_en), .wr_addr(cwr_addr[RAW-1:0]), .wr_data(cwr_data),
      .rd_addr(crd_addr[RAW-1:0]), .rd_data(crd_data)
   );

   jcj_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
      .clock(clock), .reset(reset), .in_tag(tag1_ff),
      .op_a(op_a), .op_b(op_b), .res(mac_res)
   );

   assign last_joint = JW'(count_ff - 1'b1);
   assign prev_joint = JW'(i_ff - 1'b1);
   assign zo_idx     = cnt_ff[2:0];
   assign cap_idx    = 2'(cnt_ff - 1'b1);
   assign drained    = !tag1_ff.valid && !mac_res.busy;
   assign final_col  = err_ff || (int'(i_ff) + 1 == int'(count_ff));

   // store addressing and issue of products
   always_comb begin
      jwr_en   = 1'b0;
      jwr_addr = {JW'(count_ff), row_ff, cnt_ff[1:0]};
      jwr_data = elem_ff[cnt_ff[1:0]];
      jrd_addr = {k_ff, m_ff, c_ff};
      cwr_en   = 1'b0;
      cwr_addr = mac_res.dest[AW-1:0];
      cwr_data = mac_res.value;
      crd_addr = {JW'(k_ff - 1'b1), r_ff, m_ff};
      tag_in   = '0;
      case (state_ff)
         ST_LOAD: begin
            jwr_en = 1'b1;
         end
         ST_COPY: begin
            jrd_addr = {{JW{1'b0}}, cnt_ff[3:0]};
            cwr_en   = (cnt_ff != 5'd0);
            cwr_addr = {{JW{1'b0}}, 4'(cnt_ff - 1'b1)};
            cwr_data = jrd_data;
         end
         ST_MAT: begin
            tag_in.valid = 1'b1;
            tag_in.first = (m_ff == 2'd0);
            tag_in.last  = (m_ff == 2'd3);
            tag_in.dest  = DEST_W'({k_ff, r_ff, c_ff});
         end
         ST_FETCH_E: begin
            crd_addr = {last_joint, cnt_ff[1:0], 2'd3};
         end
         ST_FETCH_ZO: begin
            if (zo_idx < 3'd3) begin
               crd_addr = {prev_joint, zo_idx[1:0], 2'd2};
            end else begin
               crd_addr = {prev_joint, 2'(zo_idx - 3'd3), 2'd3};
            end
         end
         ST_CROSS: begin
            tag_in.valid    = 1'b1;
            tag_in.first    = !cnt_ff[0];
            tag_in.last     = cnt_ff[0];
            tag_in.sub      = cnt_ff[0];
            tag_in.is_cross = 1'b1;
            tag_in.sel      = cnt_ff[2:0];
            tag_in.dest     = DEST_W'(cnt_ff[2:1]);
         end
         default: ;
      endcase
      if (mac_res.valid && !mac_res.is_cross) begin
         cwr_en = 1'b1;
      end
   end

   // operand selection at the multiplier input
   always_comb begin
      op_a = signed'(crd_data);
      op_b = signed'(jrd_data);
      if (tag1_ff.is_cross) begin
         case (tag1_ff.sel)
            3'd0:    begin op_a = z_ff[1]; op_b = o_ff[2]; end
            3'd1:    begin op_a = z_ff[2]; op_b = o_ff[1]; end
            3'd2:    begin op_a = z_ff[2]; op_b = o_ff[0]; end
            3'd3:    begin op_a = z_ff[0]; op_b = o_ff[2]; end
            3'd4:    begin op_a = z_ff[0]; op_b = o_ff[1]; end
            default: begin op_a = z_ff[1]; op_b = o_ff[0]; end
         endcase
      end
   end

   // sequencer, joint bookkeeping and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tag1_ff      <= '0;
      end else begin
         tag1_ff <= tag_in;
         // the emit step refills the output register itself
         if (rsp_valid_ff && rsp_ready && state_ff != ST_EMIT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  row_ff     <= req_row_index;
                  elem_ff[0] <= req_elem_0;
                  elem_ff[1] <= req_elem_1;
                  elem_ff[2] <= req_elem_2;
                  elem_ff[3] <= req_elem_3;
                  cnt_ff     <= '0;
                  case (req_type)
                     REQ_LOAD: begin
                        if (int'(count_ff) >= MAX_JOINTS) begin
                           ovf_ff <= 1'b1;
                        end else begin
                           state_ff <= ST_LOAD;
                        end
                     end
                     REQ_CLEAR: begin
                        count_ff <= '0;
                        ovf_ff   <= 1'b0;
                     end
                     REQ_COMPUTE: begin
                        i_ff <= '0;
                        if (count_ff == '0) begin
                           err_ff   <= 1'b1;
                           state_ff <= ST_EMIT;
                        end else begin
                           err_ff   <= 1'b0;
                           state_ff <= ST_COPY;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            ST_LOAD: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == 5'd3) begin
                  if (row_ff == 2'd3) begin
                     count_ff <= count_ff + 1'b1;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            ST_COPY: begin
               if (cnt_ff == 5'd16) begin
                  cnt_ff <= '0;
                  k_ff   <= JW'(1);
                  r_ff   <= '0;
                  c_ff   <= '0;
                  m_ff   <= '0;
                  state_ff <= (count_ff == CW'(1)) ? ST_FETCH_E : ST_MAT;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_MAT: begin
               m_ff <= m_ff + 1'b1;
               if (m_ff == 2'd3) begin
                  c_ff <= c_ff + 1'b1;
                  if (c_ff == 2'd3) begin
                     r_ff <= r_ff + 1'b1;
                     if (r_ff == 2'd3) begin
                        k_ff <= k_ff + 1'b1;
                        if (k_ff == last_joint) begin
                           state_ff <= ST_MAT_DRAIN;
                        end
                     end
                  end
               end
            end
            ST_MAT_DRAIN: begin
               if (drained) begin
                  cnt_ff   <= '0;
                  state_ff <= ST_FETCH_E;
               end
            end
            ST_FETCH_E: begin
               if (cnt_ff != 5'd0) begin
                  e_ff[cap_idx] <= signed'(crd_data);
               end
               if (cnt_ff == 5'd3) begin
                  // column 0 uses the base z axis and the end origin itself
                  z_ff[0]  <= '0;
                  z_ff[1]  <= '0;
                  z_ff[2]  <= ONE;
                  o_ff[0]  <= e_ff[0];
                  o_ff[1]  <= e_ff[1];
                  o_ff[2]  <= signed'(crd_data);
                  cnt_ff   <= '0;
                  state_ff <= ST_CROSS;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_FETCH_ZO: begin
               if (cnt_ff != 5'd0) begin
                  if (cnt_ff <= 5'd3) begin
                     z_ff[cap_idx] <= signed'(crd_data);
                  end else begin
                     o_ff[2'(cnt_ff - 5'd4)] <=
                        sat_diff(e_ff[2'(cnt_ff - 5'd4)], signed'(crd_data));
                  end
               end
               if (cnt_ff == 5'd6) begin
                  cnt_ff   <= '0;
                  state_ff <= ST_CROSS;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_CROSS: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == 5'd5) begin
                  state_ff <= ST_CROSS_DRAIN;
               end
            end
            ST_CROSS_DRAIN: begin
               if (drained) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_column_ff <= i_ff[1:0];
                  rsp_x_ff      <= err_ff ? '0 : res_ff[0];
                  rsp_y_ff      <= err_ff ? '0 : res_ff[1];
                  rsp_z_ff      <= err_ff ? '0 : res_ff[2];
                  rsp_last_ff   <= final_col;
                  rsp_status_ff <= err_ff ? STAT_EMPTY : (ovf_ff ? STAT_OVERFLOW : STAT_OK);
                  cnt_ff        <= '0;
                  if (final_col) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     i_ff     <= i_ff + 1'b1;
                     state_ff <= ST_FETCH_ZO;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
      if (mac_res.valid && mac_res.is_cross) begin
         res_ff[mac_res.dest[1:0]] <= mac_res.value;
      end
   end

   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_column = rsp_column_ff;
   assign rsp_jac_x  = rsp_x_ff;
   assign rsp_jac_y  = rsp_y_ff;
   assign rsp_jac_z  = rsp_z_ff;
   assign rsp_last   = rsp_last_ff;
   assign rsp_status = rsp_status_ff;

   // joint count never passes the store size
   assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) <= MAX_JOINTS)
      else $error("joint count beyond store size");

   // a row is only written while a joint slot is free
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOAD |-> int'(count_ff) < MAX_JOINTS)
      else $error("row write into full joint store");

   // chain sums only arrive during the chain multiply
   assert property (@(posedge clock) disable iff (reset)
      mac_res.valid && !mac_res.is_cross |-> state_ff == ST_MAT || state_ff == ST_MAT_DRAIN)
      else $error("chain sum outside chain multiply");

   // a new result appears only from the emit step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_EMIT)
      else $error("result raised outside emit");

endmodule

/* hw/rtl/jcj_ram.sv */
// ----------------------------------------------------------------------------
// jcj_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module jcj_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 48
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/jcj_mac.sv */
// ----------------------------------------------------------------------------
// jcj_mac
// shared multiplier with floor shift, accumulator and 32-bit saturation
// ----------------------------------------------------------------------------
module jcj_mac #(
   parameter int FRAC_BITS = jcj_pkg::DEF_FRAC_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  jcj_pkg::mac_tag_type      in_tag,
   input  logic signed [31:0]        op_a,
   input  logic signed [31:0]        op_b,
   output jcj_pkg::mac_res_type      res
);
   import jcj_pkg::*;

   localparam int ACC_W = 2 * DATA_W - FRAC_BITS + 2;
   localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-32){1'b0}}, 32'h7fffffff};
   localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W-32){1'b1}}, 32'h80000000};

   mac_tag_type             tag_ff;
   logic signed [63:0]      prod_ff, prod_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in, acc_base, shifted;
   logic signed [31:0]      sat_value;

   // product, floor shift and accumulate
   always_comb begin
      prod_in  = op_a * op_b;
      shifted  = signed'(ACC_W'(prod_ff >>> FRAC_BITS));
      acc_base = tag_ff.first ? '0 : acc_ff;
      acc_in   = tag_ff.sub ? acc_base - shifted : acc_base + shifted;
      if (acc_in > SAT_HI) begin
         sat_value = 32'sh7fffffff;
      end else if (acc_in < SAT_LO) begin
         sat_value = 32'sh80000000;
      end else begin
         sat_value = signed'(acc_in[31:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff <= in_tag;
      end
      prod_ff <= prod_in;
      if (tag_ff.valid) begin
         acc_ff <= acc_in;
      end
   end

   assign res.valid    = tag_ff.valid & tag_ff.last;
   assign res.busy     = tag_ff.valid;
   assign res.is_cross = tag_ff.is_cross;
   assign res.dest     = tag_ff.dest;
   assign res.value    = sat_value;

endmodule
